// ===== sv/i2c_master_bit_engine_core_macros.svh =====
// Assertion macros for the I2C master bit engine.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define I2CMBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i2cmbe_pkg.sv =====
// Package for the I2C master bit engine: command codes, phase constants,
// and the sequencer state and result types. No dependencies.
`default_nettype none

package i2cmbe_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned PhaseBits = 6;

  localparam logic [7:0] AckTimeoutReset = 8'd200;

  // Write: three phases per bit, then release, poll, and one of two endings.
  localparam logic [PhaseBits-1:0] WrPollSetup = PhaseBits'(ByteBits * 3);
  localparam logic [PhaseBits-1:0] WrPoll      = PhaseBits'(ByteBits * 3 + 1);
  localparam logic [PhaseBits-1:0] WrEndAck    = PhaseBits'(ByteBits * 3 + 2);
  localparam logic [PhaseBits-1:0] WrEndFail   = PhaseBits'(ByteBits * 3 + 3);
  // Read: one release phase, then three per bit; the last is the done tick.
  localparam logic [PhaseBits-1:0] RdLast      = PhaseBits'(ByteBits * 3);

  // Sub-phase within a bit slot (tracks the position modulo three).
  typedef enum logic [1:0] {
    SUB_DATA = 2'd0,
    SUB_HIGH = 2'd1,
    SUB_LOW  = 2'd2
  } sub_e;

  typedef struct packed {
    op_e                  op;
    logic [PhaseBits-1:0] phase;
    sub_e                 sub;
    logic [7:0]           shift;
    logic [7:0]           wait_cnt;
    logic                 scl;
    logic                 sda;
    logic [7:0]           rd_hold;
  } seq_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       ack_ok;
    logic [7:0] read_byte;
  } seq_res_t;

endpackage

`default_nettype wire

// ===== sv/i2cmbe_seq.sv =====
// Next-state and result logic of the I2C master line sequencer for one tick.
// Purely combinational; uses i2cmbe_pkg.
`default_nettype none

module i2cmbe_seq (
  input  i2cmbe_pkg::seq_state_t st_i,
  input  logic [2:0]             func_i,
  input  logic [7:0]             wr_data_i,
  input  logic                   sda_in_i,
  input  logic [7:0]             ack_timeout_i,
  output i2cmbe_pkg::seq_state_t st_o,
  output i2cmbe_pkg::seq_res_t   res_o
);

  always_comb begin
    automatic i2cmbe_pkg::seq_state_t nx;
    automatic logic                   fin;
    automatic logic                   ack;
    automatic logic [8:0]             wait_inc;

    nx       = st_i;
    fin      = 1'b0;
    ack      = 1'b0;
    wait_inc = {1'b0, st_i.wait_cnt} + 9'd1;

    // Take a new command only when idle; unused codes count as none.
    if (st_i.op == i2cmbe_pkg::OP_IDLE &&
        func_i inside {[i2cmbe_pkg::OP_START:i2cmbe_pkg::OP_READ]}) begin
      nx.op       = i2cmbe_pkg::op_e'(func_i);
      nx.phase    = '0;
      nx.sub      = i2cmbe_pkg::SUB_DATA;
      nx.wait_cnt = '0;
      nx.shift    = (func_i == i2cmbe_pkg::OP_WRITE) ? wr_data_i : 8'd0;
      wait_inc    = 9'd1;
    end

    case (nx.op)
      i2cmbe_pkg::OP_START: begin
        case (nx.phase)
          6'd0:    nx.sda = 1'b1;
          6'd1:    nx.scl = 1'b1;
          6'd2:    nx.sda = 1'b0;
          default: begin
            nx.scl = 1'b0;
            fin    = 1'b1;
          end
        endcase
        nx.phase = nx.phase + 6'd1;
      end
      i2cmbe_pkg::OP_STOP: begin
        case (nx.phase)
          6'd0:    nx.sda = 1'b0;
          6'd1:    nx.scl = 1'b1;
          default: begin
            nx.sda = 1'b1;
            fin    = 1'b1;
          end
        endcase
        nx.phase = nx.phase + 6'd1;
      end
      i2cmbe_pkg::OP_WRITE: begin
        if (nx.phase < i2cmbe_pkg::WrPollSetup) begin
          case (nx.sub)
            i2cmbe_pkg::SUB_DATA: begin
              nx.sda   = nx.shift[7];
              nx.shift = {nx.shift[6:0], 1'b0};
              nx.sub   = i2cmbe_pkg::SUB_HIGH;
            end
            i2cmbe_pkg::SUB_HIGH: begin
              nx.scl = 1'b1;
              nx.sub = i2cmbe_pkg::SUB_LOW;
            end
            default: begin
              nx.scl = 1'b0;
              nx.sub = i2cmbe_pkg::SUB_DATA;
            end
          endcase
          nx.phase = nx.phase + 6'd1;
        end else if (nx.phase == i2cmbe_pkg::WrPollSetup) begin
          nx.sda   = 1'b1;
          nx.phase = i2cmbe_pkg::WrPoll;
        end else if (nx.phase == i2cmbe_pkg::WrPoll) begin
          nx.scl = 1'b1;
          if (!sda_in_i) begin
            nx.phase = i2cmbe_pkg::WrEndAck;
          end else if (wait_inc > {1'b0, ack_timeout_i}) begin
            nx.phase = i2cmbe_pkg::WrEndFail;
          end else begin
            nx.wait_cnt = wait_inc[7:0];
          end
        end else begin
          nx.scl = 1'b0;
          ack    = (nx.phase == i2cmbe_pkg::WrEndAck);
          fin    = 1'b1;
        end
      end
      i2cmbe_pkg::OP_READ: begin
        if (nx.phase == '0) begin
          nx.sda = 1'b1;
        end else if (nx.phase <= i2cmbe_pkg::RdLast) begin
          case (nx.sub)
            i2cmbe_pkg::SUB_DATA: begin
              nx.scl = 1'b1;
              nx.sub = i2cmbe_pkg::SUB_HIGH;
            end
            i2cmbe_pkg::SUB_HIGH: begin
              nx.shift = {nx.shift[6:0], sda_in_i};
              nx.sub   = i2cmbe_pkg::SUB_LOW;
            end
            default: begin
              nx.scl = 1'b0;
              nx.sub = i2cmbe_pkg::SUB_DATA;
              if (nx.phase == i2cmbe_pkg::RdLast) begin
                nx.rd_hold = nx.shift;
                fin        = 1'b1;
              end
            end
          endcase
        end else begin
          fin = 1'b1;
        end
        nx.phase = nx.phase + 6'd1;
      end
      default: nx.op = i2cmbe_pkg::OP_IDLE;
    endcase

    if (fin) begin
      nx.op       = i2cmbe_pkg::OP_IDLE;
      nx.phase    = '0;
      nx.sub      = i2cmbe_pkg::SUB_DATA;
      nx.wait_cnt = '0;
    end

    st_o            = nx;
    res_o.scl       = nx.scl;
    res_o.sda       = nx.sda;
    res_o.busy      = (nx.op != i2cmbe_pkg::OP_IDLE);
    res_o.done      = fin;
    res_o.ack_ok    = ack;
    res_o.read_byte = nx.rd_hold;
  end

endmodule

`default_nettype wire

// ===== sv/i2c_master_bit_engine_core.sv =====
// I2C master bit engine, top level: sequencer state, result register, config.
// Depends on i2cmbe_pkg, i2cmbe_seq and i2c_master_bit_engine_core_macros.svh.
//
// Each input transfer is one bus delay tick and yields exactly one result
// transfer. When idle, a tick may carry a command (start, stop, write byte,
// read byte); the engine then walks SCL and SDA through the command's line
// sequence, one step per tick, and reports the driven levels, busy, done,
// the acknowledge status of a write and the byte of the last read. Start
// takes 4 ticks, stop 3, read 25, write 26 plus one tick per acknowledge
// poll (at least one); the poll ends on SDA low or fails once more than
// ack_timeout high samples are seen.
// Throughput is one tick per clock: the whole step is one combinational pass
// from the state register into the result register, and a new tick is taken
// while the previous result waits as long as the consumer takes it in the
// same cycle. The result becomes valid in the cycle after the input transfer.
// ack_timeout is written through the config channel (always ready) and must
// only change while no tick is in flight.
`default_nettype none

`include "i2c_master_bit_engine_core_macros.svh"

module i2c_master_bit_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // tick input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [7:0] wr_data_i,
  input  logic       sda_in_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       ack_ok_o,
  output logic [7:0] read_byte_o,
  // config channel (ack_timeout)
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  i2cmbe_pkg::seq_state_t state_q, state_d;
  i2cmbe_pkg::seq_res_t   res_q, res_d;
  logic                   out_valid_q;
  logic [7:0]             ack_timeout_q;
  logic                   in_xfer;

  // Take a tick whenever the result slot is empty or drains this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  i2cmbe_seq u_seq (
    .st_i          (state_q),
    .func_i        (func_i),
    .wr_data_i     (wr_data_i),
    .sda_in_i      (sda_in_i),
    .ack_timeout_i (ack_timeout_q),
    .st_o          (state_d),
    .res_o         (res_d)
  );

  // Config register: hold until a config transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= i2cmbe_pkg::AckTimeoutReset;
    end else if (cfg_valid_i) begin
      ack_timeout_q <= cfg_data_i;
    end
  end

  // Sequencer state: advance one step per accepted tick; lines idle released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.op       <= i2cmbe_pkg::OP_IDLE;
      state_q.phase    <= '0;
      state_q.sub      <= i2cmbe_pkg::SUB_DATA;
      state_q.shift    <= '0;
      state_q.wait_cnt <= '0;
      state_q.scl      <= 1'b1;
      state_q.sda      <= 1'b1;
      state_q.rd_hold  <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Result slot valid: set on a tick, drop when taken without a new tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on every accepted tick.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl;
  assign sda_out_o   = res_q.sda;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign ack_ok_o    = res_q.ack_ok;
  assign read_byte_o = res_q.read_byte;

  // A finished sequence is never reported as still busy.
  `I2CMBE_ASSERT_NOW(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o, "done while busy")
  // Acknowledge status only appears on a done tick.
  `I2CMBE_ASSERT_NOW(a_ack_on_done, out_valid_o && ack_ok_o, done_res_o, "ack without done")
  // An idle sequencer sits at the first phase.
  `I2CMBE_ASSERT_NOW(a_idle_phase, state_q.op == i2cmbe_pkg::OP_IDLE, state_q.phase == '0, "idle with phase")
  // The poll counter runs only during a write.
  `I2CMBE_ASSERT_NOW(a_wait_in_write, state_q.wait_cnt != '0, state_q.op == i2cmbe_pkg::OP_WRITE, "stray wait count")

endmodule

`default_nettype wire

// ===== tb/tb_i2c_master_bit_engine_core.sv =====
// Testbench for i2c_master_bit_engine_core: drives command and tick transfers, predicts
// every result transfer with its own model of the line sequencer, and checks them in order.
// Depends on i2cmbe_pkg and the RTL of the block; needs no files or arguments.
`default_nettype none

module tb_i2c_master_bit_engine_core;

  // Command codes as carried on func_i.
  localparam logic [2:0] FUNC_NONE  = i2cmbe_pkg::OP_IDLE;
  localparam logic [2:0] FUNC_START = i2cmbe_pkg::OP_START;
  localparam logic [2:0] FUNC_STOP  = i2cmbe_pkg::OP_STOP;
  localparam logic [2:0] FUNC_WRITE = i2cmbe_pkg::OP_WRITE;
  localparam logic [2:0] FUNC_READ  = i2cmbe_pkg::OP_READ;
  // Command codes the block does not define; it must treat them as no command.
  localparam logic [2:0] FUNC_RSV5 = 3'd5;
  localparam logic [2:0] FUNC_RSV6 = 3'd6;
  localparam logic [2:0] FUNC_RSV7 = 3'd7;

  localparam int NeverAck   = 1000;   // poll count that outlasts any timeout
  localparam int CycleLimit = 200000; // generous bound for the watchdog
  localparam int HoldCycles = 80;     // long receiver hold-off
  localparam int PhaseTicks = 20;     // minimum ticks per random phase
  localparam int RandPhases = 3;

  // One directed row: optional timeout write, then one command run to completion.
  // ack_wait is the number of high SDA samples offered during the acknowledge poll,
  // rd_bits the byte offered on the read sample ticks, MSB first.
  typedef struct {
    bit                   set_cfg;
    logic [7:0]           cfg_val;
    logic [2:0]           func;
    logic [7:0]           wr;
    logic [7:0]           rd_bits;
    int                   ack_wait;
    bit                   chk;
    i2cmbe_pkg::seq_res_t want;   // result of the last tick of the row, when chk is set
  } step_row_t;

  localparam int DirRows = 21;

  // Result fields in order: scl, sda, busy, done, ack_ok, read_byte.
  step_row_t dir_tab [0:DirRows-1] = '{
    // idle tick right after reset, then the unused codes, all no-ops
    '{1'b0, 8'd0, FUNC_NONE,  8'h00, 8'h00, 0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{1'b0, 8'd0, FUNC_RSV5,  8'hFF, 8'h00, 0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{1'b0, 8'd0, FUNC_RSV6,  8'h00, 8'h00, 0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{1'b0, 8'd0, FUNC_RSV7,  8'hFF, 8'h00, 0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}},
    // stop straight from reset, then start
    '{1'b0, 8'd0, FUNC_STOP,  8'h00, 8'h00, 0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{1'b0, 8'd0, FUNC_START, 8'h00, 8'h00, 0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
    // writes at the reset timeout: immediate ack, late ack, and no ack at all
    '{1'b0, 8'd0, FUNC_WRITE, 8'hFF, 8'h00, 0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00}},
    '{1'b0, 8'd0, FUNC_WRITE, 8'h00, 8'h00, 7, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00}},
    '{1'b0, 8'd0, FUNC_WRITE, 8'h5A, 8'h00, NeverAck, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00}},
    // reads of all ones, all zeros and a mixed byte
    '{1'b0, 8'd0, FUNC_READ,  8'h00, 8'hFF, 0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'hFF}},
    '{1'b0, 8'd0, FUNC_READ,  8'hFF, 8'h00, 0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{1'b0, 8'd0, FUNC_READ,  8'h00, 8'hA5, 0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'hA5}},
    '{1'b0, 8'd0, FUNC_STOP,  8'h00, 8'h00, 0, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'hA5}},
    // zero timeout: the first high sample fails the write
    '{1'b1, 8'd0, FUNC_START, 8'h00, 8'h00, 0, 1'b0, '0},
    '{1'b0, 8'd0, FUNC_WRITE, 8'h3C, 8'h00, 1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'hA5}},
    '{1'b0, 8'd0, FUNC_WRITE, 8'hC3, 8'h00, 0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'hA5}},
    // largest timeout: a short run of high samples still ends acknowledged
    '{1'b1, 8'd255, FUNC_WRITE, 8'h81, 8'h00, 3, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'hA5}},
    // timeout of one: boundary on both sides
    '{1'b1, 8'd1, FUNC_WRITE, 8'h7E, 8'h00, 1, 1'b0, '0},
    '{1'b0, 8'd0, FUNC_WRITE, 8'h18, 8'h00, 2, 1'b0, '0},
    '{1'b0, 8'd0, FUNC_READ,  8'h00, 8'h3C, 0, 1'b0, '0},
    '{1'b0, 8'd0, FUNC_STOP,  8'h00, 8'h00, 0, 1'b0, '0}
  };

  // Clock, reset and block ports; every input starts at a known value.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [2:0] func_i      = '0;
  logic [7:0] wr_data_i   = '0;
  logic       sda_in_i    = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       scl_out_o;
  logic       sda_out_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       ack_ok_o;
  logic [7:0] read_byte_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  // Sequencer model state, starting from the reset values.
  i2cmbe_pkg::op_e eng_op      = i2cmbe_pkg::OP_IDLE;
  logic [5:0]      eng_phase   = '0;
  logic [7:0]      eng_shift   = '0;
  logic [7:0]      eng_wait    = '0;
  logic            eng_scl     = 1'b1;
  logic            eng_sda     = 1'b1;
  logic [7:0]      eng_rd      = '0;
  logic [7:0]      eng_timeout = i2cmbe_pkg::AckTimeoutReset;

  i2cmbe_pkg::seq_res_t line_exp_q [$];   // expected result transfers, oldest first

  int  cyc        = 0;
  int  faults     = 0;
  int  n_ticks    = 0;
  int  n_results  = 0;
  int  n_start    = 0;
  int  n_stop     = 0;
  int  n_write    = 0;
  int  n_read     = 0;
  int  n_acked    = 0;
  int  n_timedout = 0;
  int  n_cfg      = 0;
  int  hold_left  = 0;
  bit  hold_go    = 1'b0;
  bit  hold_seen  = 1'b0;

  i2c_master_bit_engine_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .wr_data_i   (wr_data_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .ack_ok_o    (ack_ok_o),
    .read_byte_o (read_byte_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both sides run without idling inside this window.
  function automatic bit calm_window();
    return cyc >= 600 && cyc < 1100;
  endfunction

  // Advance the sequencer model by one tick and return the levels it reports.
  function automatic i2cmbe_pkg::seq_res_t bus_step(input logic [2:0] f,
                                                    input logic [7:0] wr,
                                                    input logic       sda);
    logic [5:0]           p;
    logic                 fin;
    logic                 ack;
    i2cmbe_pkg::sub_e     sub;
    i2cmbe_pkg::seq_res_t r;
    fin = 1'b0;
    ack = 1'b0;
    // A command is taken only when idle; unused codes fall through as no command.
    if (eng_op == i2cmbe_pkg::OP_IDLE && f >= FUNC_START && f <= FUNC_READ) begin
      eng_op    = i2cmbe_pkg::op_e'(f);
      eng_phase = '0;
      eng_wait  = '0;
      eng_shift = (f == FUNC_WRITE) ? wr : 8'h00;
    end
    p = eng_phase;
    case (eng_op)
      i2cmbe_pkg::OP_START: begin
        case (p)
          6'd0: eng_sda = 1'b1;
          6'd1: eng_scl = 1'b1;
          6'd2: eng_sda = 1'b0;
          default: begin
            eng_scl = 1'b0;
            fin     = 1'b1;
          end
        endcase
        eng_phase = p + 6'd1;
      end
      i2cmbe_pkg::OP_STOP: begin
        case (p)
          6'd0: eng_sda = 1'b0;
          6'd1: eng_scl = 1'b1;
          default: begin
            eng_sda = 1'b1;
            fin     = 1'b1;
          end
        endcase
        eng_phase = p + 6'd1;
      end
      i2cmbe_pkg::OP_WRITE: begin
        if (p < i2cmbe_pkg::WrPollSetup) begin
          // Three ticks per bit: drive the data bit, raise SCL, drop SCL.
          sub = i2cmbe_pkg::sub_e'(2'(p % 3));
          case (sub)
            i2cmbe_pkg::SUB_DATA: begin
              eng_sda   = eng_shift[7];
              eng_shift = {eng_shift[6:0], 1'b0};
            end
            i2cmbe_pkg::SUB_HIGH: eng_scl = 1'b1;
            default:              eng_scl = 1'b0;
          endcase
          eng_phase = p + 6'd1;
        end else if (p == i2cmbe_pkg::WrPollSetup) begin
          eng_sda   = 1'b1;
          eng_phase = i2cmbe_pkg::WrPoll;
        end else if (p == i2cmbe_pkg::WrPoll) begin
          // Hold SCL high and poll; more high samples than the timeout fail the write.
          eng_scl = 1'b1;
          if (!sda) begin
            eng_phase = i2cmbe_pkg::WrEndAck;
          end else if (int'(eng_wait) + 1 > int'(eng_timeout)) begin
            eng_phase = i2cmbe_pkg::WrEndFail;
          end else begin
            eng_wait = eng_wait + 8'd1;
          end
        end else begin
          eng_scl = 1'b0;
          ack     = (p == i2cmbe_pkg::WrEndAck);
          fin     = 1'b1;
        end
      end
      i2cmbe_pkg::OP_READ: begin
        if (p == 6'd0) begin
          eng_sda = 1'b1;
        end else if (p <= i2cmbe_pkg::RdLast) begin
          // Read slots start one tick later: raise SCL, sample SDA, drop SCL.
          sub = i2cmbe_pkg::sub_e'(2'(p % 3));
          case (sub)
            i2cmbe_pkg::SUB_HIGH: eng_scl = 1'b1;
            i2cmbe_pkg::SUB_LOW:  eng_shift = {eng_shift[6:0], sda};
            default: begin
              eng_scl = 1'b0;
              if (p == i2cmbe_pkg::RdLast) begin
                eng_rd = eng_shift;
                fin    = 1'b1;
              end
            end
          endcase
        end else begin
          fin = 1'b1;
        end
        eng_phase = p + 6'd1;
      end
      default: eng_op = i2cmbe_pkg::OP_IDLE;
    endcase
    if (fin) begin
      eng_op    = i2cmbe_pkg::OP_IDLE;
      eng_phase = '0;
      eng_wait  = '0;
    end
    r.scl       = eng_scl;
    r.sda       = eng_sda;
    r.busy      = (eng_op != i2cmbe_pkg::OP_IDLE);
    r.done      = fin;
    r.ack_ok    = ack;
    r.read_byte = eng_rd;
    return r;
  endfunction

  function automatic void log_fault(input string what, input i2cmbe_pkg::seq_res_t want,
                                    input i2cmbe_pkg::seq_res_t got);
    faults++;
    if (faults <= 10) begin
      $display("[%0d] %s: want scl=%b sda=%b busy=%b done=%b ack=%b byte=%02h,",
               cyc, what, want.scl, want.sda, want.busy, want.done, want.ack_ok,
               want.read_byte);
      $display("      got  scl=%b sda=%b busy=%b done=%b ack=%b byte=%02h",
               got.scl, got.sda, got.busy, got.done, got.ack_ok, got.read_byte);
    end
  endfunction

  // Offer one tick, now and then after a random gap, and hold it until the transfer.
  task automatic send_tick(input logic [2:0] f, input logic [7:0] wr, input logic sda);
    if (!calm_window() && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    wr_data_i  <= wr;
    sda_in_i   <= sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic drain_bus();
    in_valid_i <= 1'b0;
    while (line_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // Write ack_timeout only while the block is idle.
  task automatic set_timeout(input logic [7:0] v);
    drain_bus();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    eng_timeout = v;
    n_cfg++;
  endtask

  // Run one command from the idle tick that carries it to its done tick. Ticks after
  // the first carry random codes, which the block must ignore while busy. SDA follows
  // rd_bits on read sample ticks and ack_wait on poll ticks, random elsewhere.
  task automatic run_cmd(input logic [2:0] f, input logic [7:0] wr, input logic [7:0] rd_bits,
                         input int ack_wait, input bit chk,
                         input i2cmbe_pkg::seq_res_t want);
    int                   polls;
    bit                   first;
    logic [2:0]           cur_f;
    logic [7:0]           cur_wr;
    logic                 s;
    i2cmbe_pkg::seq_res_t r;
    polls = 0;
    first = 1'b1;
    case (f)
      FUNC_START: n_start++;
      FUNC_STOP:  n_stop++;
      FUNC_WRITE: n_write++;
      FUNC_READ:  n_read++;
      default: ;
    endcase
    do begin
      cur_f  = first ? f : 3'($urandom_range(7));
      cur_wr = first ? wr : 8'($urandom_range(255));
      if (eng_op == i2cmbe_pkg::OP_WRITE && eng_phase == i2cmbe_pkg::WrPoll) begin
        s = (polls < ack_wait);
        polls++;
      end else if (eng_op == i2cmbe_pkg::OP_READ && eng_phase >= 6'd1 &&
                   eng_phase <= i2cmbe_pkg::RdLast &&
                   2'(eng_phase % 3) == i2cmbe_pkg::SUB_LOW) begin
        s = rd_bits[3'(7 - (eng_phase - 6'd2) / 3)];
      end else begin
        s = 1'($urandom_range(1));
      end
      r = bus_step(cur_f, cur_wr, s);
      first = 1'b0;
      if (eng_op == i2cmbe_pkg::OP_IDLE) begin
        if (f == FUNC_WRITE) begin
          if (r.ack_ok) n_acked++;
          else n_timedout++;
        end
        if (chk) r = want;
      end
      line_exp_q.push_back(r);
      n_ticks++;
      send_tick(cur_f, cur_wr, s);
    end while (eng_op != i2cmbe_pkg::OP_IDLE);
  endtask

  // Pick a random command; mostly full sequences, with some idle and unused codes.
  task automatic random_cmd();
    int         sel;
    int         aw;
    logic [2:0] f;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(3))
        0: f = FUNC_NONE;
        1: f = FUNC_RSV5;
        2: f = FUNC_RSV6;
        default: f = FUNC_RSV7;
      endcase
    end else if (sel < 30) f = FUNC_START;
    else if (sel < 45) f = FUNC_STOP;
    else if (sel < 72) f = FUNC_WRITE;
    else f = FUNC_READ;
    // Acknowledge delay: usually short, near the timeout or absent when the timeout is small.
    sel = $urandom_range(99);
    if (sel < 70 || eng_timeout > 8'd16) aw = $urandom_range(0, 3);
    else if (sel < 85) aw = int'(eng_timeout) + $urandom_range(0, 1);
    else aw = NeverAck;
    run_cmd(f, 8'($urandom_range(255)), 8'($urandom_range(255)), aw, 1'b0, '0);
  endtask

  // Receiver: random stalls, one long hold-off on request, none in the calm window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen   <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm_window() || ($urandom_range(99) >= 20);
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    i2cmbe_pkg::seq_res_t got;
    i2cmbe_pkg::seq_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{scl_out_o, sda_out_o, busy_res_o, done_res_o, ack_ok_o, read_byte_o};
      n_results++;
      if (line_exp_q.size() == 0) begin
        log_fault("result with nothing pending", '0, got);
      end else begin
        want = line_exp_q.pop_front();
        if (got !== want) log_fault("result mismatch", want, got);
      end
    end
  end

  // Cycle count and watchdog.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cyc, line_exp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] phase_to [RandPhases];
    int         start_ticks;
    phase_to[0] = 8'd3;
    phase_to[1] = 8'd0;
    phase_to[2] = 8'($urandom_range(1, 16));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walk the table.
    for (int i = 0; i < DirRows; i++) begin
      if (dir_tab[i].set_cfg) set_timeout(dir_tab[i].cfg_val);
      run_cmd(dir_tab[i].func, dir_tab[i].wr, dir_tab[i].rd_bits, dir_tab[i].ack_wait,
              dir_tab[i].chk, dir_tab[i].want);
    end

    // Random part: one phase per timeout setting, each starting from a drained block.
    for (int ph = 0; ph < RandPhases; ph++) begin
      set_timeout(phase_to[ph]);
      // Stall the receiver for a long stretch while ticks keep coming.
      if (ph == 0) hold_go <= 1'b1;
      start_ticks = n_ticks;
      while (n_ticks - start_ticks < PhaseTicks) random_cmd();
    end

    drain_bus();
    repeat (8) @(posedge clk_i);
    if (line_exp_q.size() != 0) faults += line_exp_q.size();

    $display("%0d ticks, %0d results checked, %0d timeout writes, %0d mismatches",
             n_ticks, n_results, n_cfg, faults);
    $display("commands: %0d start, %0d stop, %0d read, %0d write (%0d acked, %0d timed out)",
             n_start, n_stop, n_read, n_write, n_acked, n_timedout);
    if (faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/i2cmbe_pkg.sv
sv/i2cmbe_seq.sv
sv/i2c_master_bit_engine_core.sv
tb/tb_i2c_master_bit_engine_core.sv
